@@ hdl/fae_pkg.sv @@
// Shared constants for the frame auto-exposure block.
package fae_pkg;

    localparam int PIXEL_COUNT_BITS_DEF = 21;

    localparam int LUMA_W    = 8;
    localparam int SCALE_W   = 8;
    localparam int SHUTTER_W = 12;
    localparam int GAIN_W    = 10;
    localparam int OUT_CNT_W = 21;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 12;
    localparam int OUT_DAT_W = SHUTTER_W + GAIN_W + 2 * OUT_CNT_W;

    localparam logic [SHUTTER_W-1:0] SHUTTER_MAX   = 12'd4095;
    localparam logic [SHUTTER_W-1:0] SHUTTER_FLOOR = 12'd1;
    localparam logic [GAIN_W-1:0]    GAIN_MAX      = 10'd1023;
    localparam logic [GAIN_W-1:0]    GAIN_FLOOR    = 10'd192;
    localparam logic [OUT_CNT_W-1:0] OUT_COUNT_MAX = 21'd2097151;

    // register reset values
    localparam logic [LUMA_W-1:0]    MIN_HUE_RST       = 8'd60;
    localparam logic [LUMA_W-1:0]    MAX_HUE_RST       = 8'd250;
    localparam logic [SCALE_W-1:0]   GAIN_SCALE_RST    = 8'd16;
    localparam logic [SCALE_W-1:0]   SHUTTER_SCALE_RST = 8'd64;
    localparam logic [SHUTTER_W-1:0] SHUTTER_START_RST = 12'd1000;
    localparam logic [GAIN_W-1:0]    GAIN_START_RST    = 10'd192;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MIN_HUE       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_HUE       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_SCALE    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SHUTTER_SCALE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SHUTTER_START = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_START    = 3'd5;

endpackage

@@ hdl/fae_tally.sv @@
// Per-frame dark, bright and pixel counters with saturation.
module fae_tally
    import fae_pkg::*;
#(
    parameter int PIXEL_COUNT_BITS = PIXEL_COUNT_BITS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        accept,
    input  logic [LUMA_W-1:0]           luma_byte,
    input  logic                        frame_end,
    input  logic [LUMA_W-1:0]           min_hue,
    input  logic [LUMA_W-1:0]           max_hue,
    // counts including the pixel being accepted
    output logic [PIXEL_COUNT_BITS-1:0] dark_cnt,
    output logic [PIXEL_COUNT_BITS-1:0] bright_cnt,
    output logic [PIXEL_COUNT_BITS-1:0] pix_cnt
);

    logic [PIXEL_COUNT_BITS-1:0] dark_reg, bright_reg, pix_reg;
    logic                        is_dark, is_bright;

    assign is_dark   = (luma_byte <= min_hue);
    assign is_bright = !is_dark && (luma_byte >= max_hue);

    always_comb begin
        dark_cnt   = dark_reg;
        bright_cnt = bright_reg;
        pix_cnt    = pix_reg + PIXEL_COUNT_BITS'(pix_reg != '1);
        if (is_dark) begin
            dark_cnt = dark_reg + PIXEL_COUNT_BITS'(dark_reg != '1);
        end
        if (is_bright) begin
            bright_cnt = bright_reg + PIXEL_COUNT_BITS'(bright_reg != '1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dark_reg   <= '0;
            bright_reg <= '0;
            pix_reg    <= '0;
        end else if (accept) begin
            if (frame_end) begin
                dark_reg   <= '0;
                bright_reg <= '0;
                pix_reg    <= '0;
            end else begin
                dark_reg   <= dark_cnt;
                bright_reg <= bright_cnt;
                pix_reg    <= pix_cnt;
            end
        end
    end

endmodule

@@ hdl/fae_div.sv @@
// Restoring divider, one quotient bit per cycle.
module fae_div
    import fae_pkg::*;
#(
    parameter int NUM_W = 29,
    parameter int DEN_W = 21
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [NUM_W-1:0] numer,
    input  logic [DEN_W-1:0] denom,
    output logic             done,
    output logic [NUM_W-1:0] quotient,
    output logic [DEN_W-1:0] remainder
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [NUM_W-1:0] quo_reg, quo_next;
    logic [DEN_W-1:0] den_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg, done_reg;
    logic [DEN_W:0]   trial;
    logic             ge;

    assign trial    = {rem_reg, quo_reg[NUM_W-1]};
    assign ge       = (trial >= {1'b0, den_reg});
    assign rem_next = ge ? DEN_W'(trial - {1'b0, den_reg}) : trial[DEN_W-1:0];
    assign quo_next = {quo_reg[NUM_W-2:0], ge};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(NUM_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            quo_reg <= numer;
            den_reg <= denom;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

@@ hdl/frame_auto_exposure.sv @@
// Top level of the frame auto-exposure controller.
//
// Pixels stream in one per cycle while the sequencer is idle (luma in s_tdata,
// last pixel of the frame on s_tlast) and are sorted into dark / bright tallies
// as they arrive. The last pixel of a frame starts the adjustment sequencer:
// ST_MUL forms |dark - bright| * scale, ST_DIV_GO loads the divider, ST_DIV
// waits for the bit-serial divider (division by the frame's pixel count) to
// finish, and ST_UPDATE applies the step and clamp. While the sequencer runs,
// s_tready is low; all other pixels are accepted one per cycle. The result
// request (new shutter, new gain, dark and bright counts) waits in an output
// register, and pixels of the next frame keep flowing while it waits; only the
// next frame's adjustment stalls until it has been taken. Config writes are always
// accepted (cfg_ready is always high) and are meant for idle periods; writing
// shutter_start or gain_start also loads the live shutter or gain value.
module frame_auto_exposure
    import fae_pkg::*;
#(
    parameter int PIXEL_COUNT_BITS = PIXEL_COUNT_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // pixel stream
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,   // [7:0] luma_byte
    input  logic                 s_tlast,   // frame_end
    // result stream
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // [11:0] new_shutter, [21:12] new_gain, [42:22] dark_pixels,
    // [63:43] bright_pixels
    output logic [OUT_DAT_W-1:0] m_tdata,
    // config writes
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_data
);

    localparam int PCB    = PIXEL_COUNT_BITS;
    localparam int PROD_W = PCB + SCALE_W;
    localparam int UPD_W  = PROD_W + 1;
    localparam int CNT_W  = (PCB > OUT_CNT_W) ? PCB : OUT_CNT_W;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_MUL    = 3'd1;
    localparam logic [2:0] ST_DIV_GO = 3'd2;
    localparam logic [2:0] ST_DIV    = 3'd3;
    localparam logic [2:0] ST_UPDATE = 3'd4;

    logic [2:0]           state_reg, state_next;

    // config registers
    logic [LUMA_W-1:0]    min_hue_reg, max_hue_reg;
    logic [SCALE_W-1:0]   gain_scale_reg, shutter_scale_reg;
    logic [SHUTTER_W-1:0] shutter_start_reg;
    logic [GAIN_W-1:0]    gain_start_reg;

    // exposure state
    logic [SHUTTER_W-1:0] shutter_now_reg, shutter_now_next;
    logic [GAIN_W-1:0]    gain_now_reg, gain_now_next;

    // frame snapshot
    logic [PCB-1:0]       dk_reg, br_reg, pix_reg;
    logic                 up_reg;          // dark > bright: raise exposure
    logic                 tgt_shutter_reg; // step goes to the shutter
    logic [PROD_W-1:0]    prod_reg;

    logic                 m_tvalid_reg, m_tvalid_next;
    logic [OUT_DAT_W-1:0] m_tdata_reg;

    logic                 s_fire, cfg_fire, out_free;
    logic [PCB-1:0]       dark_cnt, bright_cnt, pix_cnt;
    logic                 frame_up;
    logic [PCB-1:0]       diff;
    logic [SCALE_W-1:0]   scale_sel;

    logic                 div_start, div_done;
    logic [PROD_W-1:0]    div_q;
    logic [PCB-1:0]       div_r;

    logic [UPD_W-1:0]     old_val, up_sum, ceil_q, dn_val;
    logic [SHUTTER_W-1:0] shutter_res;
    logic [GAIN_W-1:0]    gain_res;
    logic [CNT_W-1:0]     dk_ext, br_ext;
    logic [OUT_CNT_W-1:0] dk_out, br_out;

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_fire    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign div_start = (state_reg == ST_DIV_GO);

    fae_tally #(
        .PIXEL_COUNT_BITS(PCB)
    ) u_tally (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .accept    (s_fire),
        .luma_byte (s_tdata[LUMA_W-1:0]),
        .frame_end (s_tlast),
        .min_hue   (min_hue_reg),
        .max_hue   (max_hue_reg),
        .dark_cnt  (dark_cnt),
        .bright_cnt(bright_cnt),
        .pix_cnt   (pix_cnt)
    );

    fae_div #(
        .NUM_W(PROD_W),
        .DEN_W(PCB)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .numer    (prod_reg),
        .denom    (pix_reg),
        .done     (div_done),
        .quotient (div_q),
        .remainder(div_r)
    );

    assign frame_up  = (dark_cnt > bright_cnt);
    assign diff      = up_reg ? (dk_reg - br_reg) : (br_reg - dk_reg);
    assign scale_sel = tgt_shutter_reg ? shutter_scale_reg : gain_scale_reg;

    // Raising: old + floor(m/P). Lowering: floor((old*P - m)/P)
    // = old - ceil(m/P), or zero when that goes negative.
    always_comb begin
        old_val = tgt_shutter_reg ? UPD_W'(shutter_now_reg) : UPD_W'(gain_now_reg);
        up_sum  = old_val + UPD_W'(div_q);
        ceil_q  = UPD_W'(div_q) + UPD_W'(div_r != '0);
        dn_val  = (ceil_q >= old_val) ? '0 : (old_val - ceil_q);

        shutter_res = shutter_now_reg;
        gain_res    = gain_now_reg;
        if (tgt_shutter_reg) begin
            if (up_reg) begin
                shutter_res = (up_sum > UPD_W'(SHUTTER_MAX)) ? SHUTTER_MAX
                                                             : up_sum[SHUTTER_W-1:0];
            end else begin
                shutter_res = (dn_val < UPD_W'(SHUTTER_FLOOR)) ? SHUTTER_FLOOR
                                                               : dn_val[SHUTTER_W-1:0];
            end
        end else begin
            if (up_reg) begin
                gain_res = (up_sum > UPD_W'(GAIN_MAX)) ? GAIN_MAX : up_sum[GAIN_W-1:0];
            end else begin
                gain_res = (dn_val < UPD_W'(GAIN_FLOOR)) ? GAIN_FLOOR : dn_val[GAIN_W-1:0];
            end
        end
    end

    // reported counts saturate at the 21-bit field
    assign dk_ext = CNT_W'(dk_reg);
    assign br_ext = CNT_W'(br_reg);
    assign dk_out = (dk_ext > CNT_W'(OUT_COUNT_MAX)) ? OUT_COUNT_MAX : dk_ext[OUT_CNT_W-1:0];
    assign br_out = (br_ext > CNT_W'(OUT_COUNT_MAX)) ? OUT_COUNT_MAX : br_ext[OUT_CNT_W-1:0];

    // sequencer
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_fire && s_tlast) begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                state_next = ST_DIV_GO;
            end
            ST_DIV_GO: begin
                state_next = ST_DIV;
            end
            ST_DIV: begin
                if (div_done) begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end
        if (state_reg == ST_UPDATE && out_free) begin
            m_tvalid_next = 1'b1;
        end
    end

    always_comb begin
        shutter_now_next = shutter_now_reg;
        gain_now_next    = gain_now_reg;
        if (state_reg == ST_UPDATE && out_free) begin
            shutter_now_next = shutter_res;
            gain_now_next    = gain_res;
        end
        if (cfg_fire && cfg_index == REG_SHUTTER_START) begin
            shutter_now_next = cfg_data[SHUTTER_W-1:0];
        end
        if (cfg_fire && cfg_index == REG_GAIN_START) begin
            gain_now_next = cfg_data[GAIN_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= ST_IDLE;
            m_tvalid_reg      <= 1'b0;
            min_hue_reg       <= MIN_HUE_RST;
            max_hue_reg       <= MAX_HUE_RST;
            gain_scale_reg    <= GAIN_SCALE_RST;
            shutter_scale_reg <= SHUTTER_SCALE_RST;
            shutter_start_reg <= SHUTTER_START_RST;
            gain_start_reg    <= GAIN_START_RST;
            shutter_now_reg   <= SHUTTER_START_RST;
            gain_now_reg      <= GAIN_START_RST;
        end else begin
            state_reg       <= state_next;
            m_tvalid_reg    <= m_tvalid_next;
            shutter_now_reg <= shutter_now_next;
            gain_now_reg    <= gain_now_next;
            if (cfg_fire) begin
                case (cfg_index)
                    REG_MIN_HUE:       min_hue_reg       <= cfg_data[LUMA_W-1:0];
                    REG_MAX_HUE:       max_hue_reg       <= cfg_data[LUMA_W-1:0];
                    REG_GAIN_SCALE:    gain_scale_reg    <= cfg_data[SCALE_W-1:0];
                    REG_SHUTTER_SCALE: shutter_scale_reg <= cfg_data[SCALE_W-1:0];
                    REG_SHUTTER_START: shutter_start_reg <= cfg_data[SHUTTER_W-1:0];
                    REG_GAIN_START:    gain_start_reg    <= cfg_data[GAIN_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_fire && s_tlast) begin
            dk_reg  <= dark_cnt;
            br_reg  <= bright_cnt;
            pix_reg <= pix_cnt;
            up_reg  <= frame_up;
            tgt_shutter_reg <= frame_up ? (shutter_now_reg < SHUTTER_MAX)
                                        : !(gain_now_reg > GAIN_FLOOR);
        end
        if (state_reg == ST_MUL) begin
            prod_reg <= PROD_W'(diff) * PROD_W'(scale_sel);
        end
        if (state_reg == ST_UPDATE && out_free) begin
            m_tdata_reg <= {br_out, dk_out, gain_res, shutter_res};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // the start registers only hold the last written preset; the live values
    // are loaded alongside, so they must agree right after a preset write
    a_preset_load: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(cfg_fire) && $past(cfg_index) == REG_SHUTTER_START
        |-> shutter_now_reg == shutter_start_reg)
        else $error("shutter preset not loaded");

    a_div_done_state: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> state_reg == ST_DIV)
        else $error("divider finished outside its wait state");

    a_result_from_update: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg) == ST_UPDATE)
        else $error("result appeared without an update");

    a_frame_end_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && s_tlast |=> state_reg == ST_MUL && !s_tready)
        else $error("frame end did not start the adjustment");

    a_gain_preset_load: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(cfg_fire) && $past(cfg_index) == REG_GAIN_START
        |-> gain_now_reg == gain_start_reg)
        else $error("gain preset not loaded");

endmodule

@@ tb/tb.sv @@
// Self-checking testbench for frame_auto_exposure: streams frames, predicts exposure updates.
`timescale 1ns / 100ps

module tb;
    import fae_pkg::*;

    // tally width of the instance under test
    localparam int PIX_W = PIXEL_COUNT_BITS_DEF;
    localparam logic [PIX_W-1:0] TALLY_FULL = '1;

    // settle time after the last pixel, covering the adjustment with margin
    localparam int SETTLE_CYCLES = PIXEL_COUNT_BITS_DEF + 27;
    // long result hold-off used to back the block up into its pixel input
    localparam int HOLD_CYCLES = 400;
    // cycles without any handshake before the run is declared hung
    localparam int QUIET_LIMIT = 20000;
    // pixels per configuration setting in the random part
    localparam int PIXELS_PER_SETTING = 150;

    // indexes with no register behind them
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

    typedef enum {SET_LOWEST, SET_HIGHEST, SET_RANDOM} setting_kind_t;

    // one result request, shutter in the low bits as on m_tdata
    typedef struct packed {
        logic [OUT_CNT_W-1:0] bright;
        logic [OUT_CNT_W-1:0] dark;
        logic [GAIN_W-1:0]    gain;
        logic [SHUTTER_W-1:0] shutter;
    } exposure_t;

    // ---------------------------------------------------------------- DUT I/O
    logic                 aclk;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [7:0]           s_tdata   = '0;   // [7:0] luma_byte
    logic                 s_tlast   = 1'b0; // frame_end
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    // [11:0] new_shutter, [21:12] new_gain, [42:22] dark_pixels, [63:43] bright_pixels
    logic [OUT_DAT_W-1:0] m_tdata;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DAT_W-1:0] cfg_data  = '0;

    frame_auto_exposure dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // ------------------------------------------------------ exposure predictor
    // register copies
    logic [LUMA_W-1:0]    min_hue_q, max_hue_q;
    logic [SCALE_W-1:0]   gain_scale_q, shutter_scale_q;
    logic [SHUTTER_W-1:0] shutter_start_q;
    logic [GAIN_W-1:0]    gain_start_q;
    // running state
    logic [PIX_W-1:0]     dark_tally, bright_tally, pixel_tally;
    logic [SHUTTER_W-1:0] shutter_now;
    logic [GAIN_W-1:0]    gain_now;

    exposure_t pending_exposure[$];

    int errors       = 0;
    int pixels_seen  = 0;
    int frames_seen  = 0;
    int results_seen = 0;
    int writes_seen  = 0;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    bit results_held   = 1'b0;
    event hold_off_ev;

    function automatic void load_reset_settings();
        min_hue_q       = MIN_HUE_RST;
        max_hue_q       = MAX_HUE_RST;
        gain_scale_q    = GAIN_SCALE_RST;
        shutter_scale_q = SHUTTER_SCALE_RST;
        shutter_start_q = SHUTTER_START_RST;
        gain_start_q    = GAIN_START_RST;
        dark_tally      = '0;
        bright_tally    = '0;
        pixel_tally     = '0;
        shutter_now     = SHUTTER_START_RST;
        gain_now        = GAIN_START_RST;
    endfunction

    function automatic void apply_register_write(logic [CFG_IDX_W-1:0] idx,
                                                 logic [CFG_DAT_W-1:0] value);
        case (idx)
            REG_MIN_HUE:       min_hue_q       = value[LUMA_W-1:0];
            REG_MAX_HUE:       max_hue_q       = value[LUMA_W-1:0];
            REG_GAIN_SCALE:    gain_scale_q    = value[SCALE_W-1:0];
            REG_SHUTTER_SCALE: shutter_scale_q = value[SCALE_W-1:0];
            REG_SHUTTER_START: begin
                // preset also loads the live value
                shutter_start_q = value[SHUTTER_W-1:0];
                shutter_now     = value[SHUTTER_W-1:0];
            end
            REG_GAIN_START: begin
                gain_start_q = value[GAIN_W-1:0];
                gain_now     = value[GAIN_W-1:0];
            end
            default: ;
        endcase
    endfunction

    // floor((old*P - mag*scale)/P), zero when the numerator is not positive
    function automatic longint unsigned shrink_setting(longint unsigned old,
                                                       longint unsigned mag,
                                                       longint unsigned scale,
                                                       longint unsigned pix);
        longint unsigned base, sub;
        base = old * pix;
        sub  = mag * scale;
        return (sub >= base) ? 0 : (base - sub) / pix;
    endfunction

    function automatic void track_pixel(logic [7:0] luma, logic last);
        longint unsigned pix, dk, br, v;
        exposure_t res;
        if (pixel_tally != TALLY_FULL) pixel_tally++;
        // dark wins when the thresholds cross
        if (luma <= min_hue_q) begin
            if (dark_tally != TALLY_FULL) dark_tally++;
        end else if (luma >= max_hue_q) begin
            if (bright_tally != TALLY_FULL) bright_tally++;
        end
        if (!last) return;

        pix = pixel_tally;
        dk  = dark_tally;
        br  = bright_tally;
        if (dk > br) begin
            // too dark: open the shutter first, then raise gain
            if (shutter_now < SHUTTER_MAX) begin
                v = shutter_now + ((dk - br) * shutter_scale_q) / pix;
                shutter_now = (v > SHUTTER_MAX) ? SHUTTER_MAX : SHUTTER_W'(v);
            end else begin
                v = gain_now + ((dk - br) * gain_scale_q) / pix;
                gain_now = (v > GAIN_MAX) ? GAIN_MAX : GAIN_W'(v);
            end
        end else begin
            // too bright or balanced: back off gain first, then the shutter
            if (gain_now > GAIN_FLOOR) begin
                v = shrink_setting(gain_now, br - dk, gain_scale_q, pix);
                gain_now = (v < GAIN_FLOOR) ? GAIN_FLOOR : GAIN_W'(v);
            end else begin
                v = shrink_setting(shutter_now, br - dk, shutter_scale_q, pix);
                shutter_now = (v < SHUTTER_FLOOR) ? SHUTTER_FLOOR : SHUTTER_W'(v);
            end
        end

        res.shutter = shutter_now;
        res.gain    = gain_now;
        res.dark    = (dk > OUT_COUNT_MAX) ? OUT_COUNT_MAX : OUT_CNT_W'(dk);
        res.bright  = (br > OUT_COUNT_MAX) ? OUT_COUNT_MAX : OUT_CNT_W'(br);
        pending_exposure.push_back(res);
        dark_tally   = '0;
        bright_tally = '0;
        pixel_tally  = '0;
    endfunction

    function automatic void compare_field(string label, int unsigned want, int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, label, want, got);
            errors++;
        end
    endfunction

    // ------------------------------------------------------ monitor / checker
    // all handshakes are sampled at the edge, before the NBA updates land
    always @(posedge aclk) begin
        exposure_t want, got;
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                apply_register_write(cfg_index, cfg_data);
                writes_seen++;
            end
            if (s_tvalid && s_tready) begin
                pixels_seen++;
                if (s_tlast) frames_seen++;
                track_pixel(s_tdata, s_tlast);
            end
            if (m_tvalid && m_tready) begin
                results_seen++;
                got = m_tdata;
                if (pending_exposure.size() == 0) begin
                    $display("%0t: result request with no frame pending, got %h",
                             $time, got);
                    errors++;
                end else begin
                    want = pending_exposure.pop_front();
                    compare_field("new_shutter", want.shutter, got.shutter);
                    compare_field("new_gain", want.gain, got.gain);
                    compare_field("dark_pixels", want.dark, got.dark);
                    compare_field("bright_pixels", want.bright, got.bright);
                end
            end
        end
    end

    // result side ready, random stalls plus an occasional long hold-off
    always @(posedge aclk) begin
        m_tready <= !results_held && ($urandom_range(0, 99) >= recv_stall_pct);
    end

    initial begin
        forever begin
            @(hold_off_ev);
            results_held = 1'b1;
            repeat (HOLD_CYCLES) @(posedge aclk);
            results_held = 1'b0;
        end
    end

    // hang detector: counts cycles where nothing moves on any channel
    int quiet_cycles = 0;
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
            $display("CHECKS FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------ drivers
    task automatic send_pixel(logic [7:0] luma, logic last);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= luma;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    task automatic end_writes();
        cfg_valid <= 1'b0;
    endtask

    // stop the pixel stream, let every pending frame come out, then let the
    // adjustment sequencer finish before anything is reprogrammed; the first
    // edge lets the monitor record the last accepted pixel
    task automatic settle_block();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_exposure.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic program_settings(setting_kind_t kind);
        settle_block();
        case (kind)
            SET_LOWEST: begin
                write_reg(REG_MIN_HUE, '0);
                write_reg(REG_MAX_HUE, '0);
                write_reg(REG_GAIN_SCALE, '0);
                write_reg(REG_SHUTTER_SCALE, '0);
                write_reg(REG_SHUTTER_START, CFG_DAT_W'(SHUTTER_FLOOR));
                write_reg(REG_GAIN_START, '0);
            end
            SET_HIGHEST: begin
                // all ones also checks that upper data bits are dropped
                write_reg(REG_MIN_HUE, '1);
                write_reg(REG_MAX_HUE, '1);
                write_reg(REG_GAIN_SCALE, '1);
                write_reg(REG_SHUTTER_SCALE, '1);
                write_reg(REG_SHUTTER_START, '1);
                write_reg(REG_GAIN_START, '1);
            end
            default: begin
                write_reg(REG_MIN_HUE, CFG_DAT_W'($urandom_range(0, 4095)));
                write_reg(REG_MAX_HUE, CFG_DAT_W'($urandom_range(0, 4095)));
                write_reg(REG_GAIN_SCALE, CFG_DAT_W'($urandom_range(0, 4095)));
                write_reg(REG_SHUTTER_SCALE, CFG_DAT_W'($urandom_range(0, 4095)));
                write_reg(REG_SHUTTER_START, CFG_DAT_W'($urandom_range(1, 4095)));
                write_reg(REG_GAIN_START, CFG_DAT_W'($urandom_range(0, 4095)));
            end
        endcase
        end_writes();
    endtask

    // one frame with a random dark / bright mix; mostly short, now and then long
    task automatic send_random_frame(output int len);
        int dark_pct, bright_pct, pick;
        logic [7:0] luma;
        len = ($urandom_range(0, 19) == 0) ? $urandom_range(100, 400) : $urandom_range(1, 24);
        dark_pct   = $urandom_range(0, 100);
        bright_pct = $urandom_range(0, 100 - dark_pct);
        for (int i = 0; i < len; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < dark_pct)
                luma = 8'($urandom_range(0, min_hue_q));
            else if (pick < dark_pct + bright_pct)
                luma = 8'($urandom_range(max_hue_q, 255));
            else
                luma = 8'($urandom_range(0, 255));
            send_pixel(luma, i == len - 1);
        end
    endtask

    // ------------------------------------------------------ tests
    // defaults after reset; luma right at and next to both thresholds
    task automatic test_threshold_edges();
        send_pixel(8'd0, 1'b1);
        send_pixel(8'd255, 1'b1);
        send_pixel(MIN_HUE_RST, 1'b0);
        send_pixel(MIN_HUE_RST + 8'd1, 1'b0);
        send_pixel(MAX_HUE_RST - 8'd1, 1'b0);
        send_pixel(MAX_HUE_RST, 1'b1);
    endtask

    // shutter ceiling, gain ceiling, then gain floor and handover to the shutter
    task automatic test_clamps();
        settle_block();
        write_reg(REG_SHUTTER_SCALE, 12'd255);
        write_reg(REG_GAIN_SCALE, 12'd255);
        write_reg(REG_SHUTTER_START, 12'd4090);
        write_reg(REG_GAIN_START, 12'd700);
        end_writes();
        repeat (3) send_pixel(8'd0, 1'b1);
        send_pixel(8'd255, 1'b1);
        settle_block();
        write_reg(REG_GAIN_START, 12'd200);
        end_writes();
        send_pixel(8'd255, 1'b1);
        send_pixel(8'd255, 1'b1);
    endtask

    // shutter preset of zero: held as written, lifted to one by a darkening step
    task automatic test_preset_edges();
        settle_block();
        write_reg(REG_SHUTTER_START, 12'd0);
        end_writes();
        send_pixel(8'd255, 1'b1);
        settle_block();
        write_reg(REG_SHUTTER_START, 12'd0);
        write_reg(REG_SHUTTER_SCALE, 12'd0);
        end_writes();
        send_pixel(8'd0, 1'b1);
    endtask

    // min_hue above max_hue: the dark test must win
    task automatic test_crossed_thresholds();
        settle_block();
        write_reg(REG_MIN_HUE, 12'd200);
        write_reg(REG_MAX_HUE, 12'd100);
        write_reg(REG_SHUTTER_SCALE, 12'd64);
        write_reg(REG_SHUTTER_START, 12'd2000);
        end_writes();
        send_pixel(8'd150, 1'b0);
        send_pixel(8'd50, 1'b0);
        send_pixel(8'd255, 1'b0);
        send_pixel(8'd0, 1'b1);
    endtask

    // writes to unmapped indexes change nothing
    task automatic test_unknown_register();
        settle_block();
        write_reg(REG_SPARE_6, '1);
        write_reg(REG_SPARE_7, '1);
        end_writes();
        send_pixel(8'd128, 1'b1);
    endtask

    // hold results off long enough that the next frame's adjustment blocks pixels
    task automatic test_result_backpressure();
        settle_block();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        -> hold_off_ev;
        for (int f = 0; f < 8; f++) begin
            send_pixel(8'($urandom_range(0, 255)), 1'b0);
            send_pixel(8'($urandom_range(0, 255)), 1'b0);
            send_pixel(8'($urandom_range(0, 255)), 1'b1);
        end
    endtask

    task automatic test_random_traffic(int idle_pct, int stall_pct,
                                       setting_kind_t first, setting_kind_t second);
        int sent, len;
        for (int k = 0; k < 2; k++) begin
            program_settings(k == 0 ? first : second);
            send_idle_pct  = idle_pct;
            recv_stall_pct = stall_pct;
            sent = 0;
            while (sent < PIXELS_PER_SETTING) begin
                send_random_frame(len);
                sent += len;
            end
        end
    endtask

    // ------------------------------------------------------ sequence
    initial begin
        load_reset_settings();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_threshold_edges();
        test_clamps();
        test_preset_edges();
        test_crossed_thresholds();
        test_unknown_register();
        test_result_backpressure();
        test_random_traffic(0, 0, SET_LOWEST, SET_RANDOM);
        test_random_traffic(63, 0, SET_HIGHEST, SET_RANDOM);
        test_random_traffic(0, 63, SET_RANDOM, SET_RANDOM);
        test_random_traffic(11, 11, SET_RANDOM, SET_LOWEST);
        settle_block();

        $display("Streamed %0d pixels in %0d frames, checked %0d exposure updates,",
                 pixels_seen, frames_seen, results_seen);
        $display("with %0d register writes across four stall patterns and one long hold-off.",
                 writes_seen);
        if (errors == 0 && pending_exposure.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

@@ files.f @@
hdl/fae_pkg.sv
hdl/fae_tally.sv
hdl/fae_div.sv
hdl/frame_auto_exposure.sv
tb/tb.sv
